// ===== src/fmrt_pkg.sv =====
package fmrt_pkg;

	// Table and position geometry.
	localparam int FRAGMENTS = 64;
	localparam int FRAG_IDX_W = 6;
	localparam int FRAG_CNT_W = 7;
	localparam int POS_W = 40;
	localparam int LEN_W = 15;
	localparam int MAX_READ_BYTES = 16384;
	localparam int WORD_W = 32;
	localparam int SBYTE_W = 9;
	localparam int CHUNK_W = 10;
	localparam int SECTOR_BYTES = 512;
	localparam int UNIT_SHIFT = 11;
	localparam int SECTOR_SHIFT = 9;
	localparam int UNIT_W = POS_W - UNIT_SHIFT;
	localparam int SECTOR_W = POS_W - SECTOR_SHIFT;
	localparam int AMT_W = 41;
	localparam int CFG_W = 40;

	// Input tdata layout, lowest field first.
	localparam int IN_DATA_W = 160;
	localparam int IN_IDX_LO = 0;
	localparam int IN_START_LO = 6;
	localparam int IN_LBA_LO = 38;
	localparam int IN_SIZE_LO = 70;
	localparam int IN_ORIGIN_LO = 102;
	localparam int IN_AMT_LO = 104;
	localparam int IN_LEN_LO = 145;

	// Output tdata width, padded to whole bytes.
	localparam int OUT_DATA_W = 104;

	// Item kinds carried on the input tuser.
	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_SEEK = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	// Seek origins.
	localparam logic [1:0] ORG_START = 2'd0;
	localparam logic [1:0] ORG_CURRENT = 2'd1;
	localparam logic [1:0] ORG_END = 2'd2;

	// Configuration register indexes.
	localparam logic REG_FRAG_COUNT = 1'b0;
	localparam logic REG_FILE_LENGTH = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic look;
		logic test;
		logic out_load;
		logic out_single;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic start_read;
		logic match;
		logic search_end;
		logic last_chunk;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== src/fmrt_ctrl.sv =====
module fmrt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fmrt_pkg::dp_sts_t  sts,
	output fmrt_pkg::ctl_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SINGLE = 5'b00010,
		ST_LOOK   = 5'b00100,
		ST_TEST   = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = sts.start_read ? ST_LOOK : ST_SINGLE;
				end
			end
			ST_SINGLE: begin
				if (sts.out_free) begin
					cmd.out_single = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				state_d = ST_TEST;
			end
			ST_TEST: begin
				cmd.test = 1'b1;
				state_d = (sts.match || sts.search_end) ? ST_EMIT : ST_LOOK;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = sts.last_chunk ? ST_IDLE : ST_LOOK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/fmrt_dpath.sv =====
module fmrt_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [1:0]                          in_mode,
	input  logic [fmrt_pkg::IN_DATA_W-1:0]      in_data,
	input  logic                                cfg_wr_en,
	input  logic                                cfg_index,
	input  logic [fmrt_pkg::CFG_W-1:0]          cfg_wdata,
	input  fmrt_pkg::ctl_cmd_t                  cmd,
	output fmrt_pkg::dp_sts_t                   sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [fmrt_pkg::OUT_DATA_W-1:0]     out_data,
	output logic                                out_status,
	output logic                                out_last
);

	localparam int W = fmrt_pkg::WORD_W;
	localparam int ENT_W = 3 * W;

	// Input fields.
	logic [fmrt_pkg::FRAG_IDX_W-1:0] f_idx;
	logic [W-1:0]                    f_start;
	logic [W-1:0]                    f_lba;
	logic [W-1:0]                    f_size;
	logic [1:0]                      f_origin;
	logic [fmrt_pkg::AMT_W-1:0]      f_amt;
	logic [fmrt_pkg::LEN_W-1:0]      f_len;

	assign f_idx    = in_data[fmrt_pkg::IN_IDX_LO +: fmrt_pkg::FRAG_IDX_W];
	assign f_start  = in_data[fmrt_pkg::IN_START_LO +: W];
	assign f_lba    = in_data[fmrt_pkg::IN_LBA_LO +: W];
	assign f_size   = in_data[fmrt_pkg::IN_SIZE_LO +: W];
	assign f_origin = in_data[fmrt_pkg::IN_ORIGIN_LO +: 2];
	assign f_amt    = in_data[fmrt_pkg::IN_AMT_LO +: fmrt_pkg::AMT_W];
	assign f_len    = in_data[fmrt_pkg::IN_LEN_LO +: fmrt_pkg::LEN_W];

	// Registers.
	logic [fmrt_pkg::FRAG_CNT_W-1:0] frag_count_q;
	logic [fmrt_pkg::POS_W-1:0]      file_len_q;
	logic [fmrt_pkg::POS_W-1:0]      pos_q;
	logic [fmrt_pkg::LEN_W-1:0]      left_q;
	logic [fmrt_pkg::FRAG_IDX_W-1:0] idx_q;
	logic                            status_q;
	logic [ENT_W-1:0]                rd_q;
	logic [W-1:0]                    fb_start_q;
	logic [W-1:0]                    fb_lba_q;
	logic [W-1:0]                    sel_start_q;
	logic [W-1:0]                    sel_lba_q;
	logic [fmrt_pkg::FRAG_IDX_W-1:0] hit_q;
	logic                            out_valid_q;
	logic [fmrt_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                            out_status_q;
	logic                            out_last_q;

	// Fragment table: start unit, disk sector and byte size per entry.
	logic [ENT_W-1:0] table_q [fmrt_pkg::FRAGMENTS];

	always_ff @(posedge clk) begin
		if (cmd.accept && in_mode == fmrt_pkg::MODE_LOAD) begin
			table_q[f_idx] <= {f_size, f_lba, f_start};
		end
		if (cmd.look) begin
			rd_q <= table_q[idx_q];
		end
	end

	// Range test on the entry read last cycle.
	logic [W-1:0]                    rd_start;
	logic [W-1:0]                    rd_lba;
	logic [W-1:0]                    rd_size;
	logic [fmrt_pkg::UNIT_W-1:0]     unit;
	logic [W:0]                      hi_unit;
	logic [fmrt_pkg::FRAG_CNT_W-1:0] n_eff;
	logic [fmrt_pkg::FRAG_CNT_W-1:0] idx_next;

	assign rd_start = rd_q[0 +: W];
	assign rd_lba   = rd_q[W +: W];
	assign rd_size  = rd_q[2*W +: W];
	assign unit     = pos_q[fmrt_pkg::POS_W-1:fmrt_pkg::UNIT_SHIFT];
	assign hi_unit  = {1'b0, rd_start}
		+ {{(fmrt_pkg::UNIT_SHIFT+1){1'b0}}, rd_size[W-1:fmrt_pkg::UNIT_SHIFT]};
	assign n_eff    = (frag_count_q > fmrt_pkg::FRAG_CNT_W'(fmrt_pkg::FRAGMENTS))
		? fmrt_pkg::FRAG_CNT_W'(fmrt_pkg::FRAGMENTS) : frag_count_q;
	assign idx_next = {1'b0, idx_q} + fmrt_pkg::FRAG_CNT_W'(1);

	assign sts.match = ({1'b0, idx_q} < n_eff)
		&& ({{(W-fmrt_pkg::UNIT_W){1'b0}}, unit} >= rd_start)
		&& ({{(W+1-fmrt_pkg::UNIT_W){1'b0}}, unit} < hi_unit);
	assign sts.search_end = idx_next >= n_eff;

	// Chunk size: rest of the current sector, capped by the bytes left.
	logic [fmrt_pkg::SBYTE_W-1:0] sbyte;
	logic [fmrt_pkg::CHUNK_W-1:0] room;
	logic [fmrt_pkg::CHUNK_W-1:0] chunk;
	logic [fmrt_pkg::LEN_W-1:0]   chunk_ext;

	assign sbyte = pos_q[fmrt_pkg::SBYTE_W-1:0];
	assign room  = fmrt_pkg::CHUNK_W'(fmrt_pkg::SECTOR_BYTES)
		- {1'b0, sbyte};
	assign chunk = ({{(fmrt_pkg::LEN_W-fmrt_pkg::CHUNK_W){1'b0}}, room} > left_q)
		? left_q[fmrt_pkg::CHUNK_W-1:0] : room;
	assign chunk_ext = {{(fmrt_pkg::LEN_W-fmrt_pkg::CHUNK_W){1'b0}}, chunk};
	assign sts.last_chunk = left_q == chunk_ext;

	// Disk sector of the chunk, wrapping at 32 bits.
	logic [W-1:0] sector;
	logic [W-1:0] disk_lba;

	assign sector   = W'(pos_q[fmrt_pkg::POS_W-1:fmrt_pkg::SECTOR_SHIFT]);
	assign disk_lba = sel_lba_q + sector - {sel_start_q[W-3:0], 2'b00};

	// Seek target and saturated read length.
	logic [fmrt_pkg::POS_W-1:0] seek_base;
	logic [fmrt_pkg::POS_W-1:0] seek_sum;
	logic [fmrt_pkg::LEN_W-1:0] len_sat;

	assign seek_base = (f_origin == fmrt_pkg::ORG_CURRENT) ? pos_q : file_len_q;
	assign seek_sum  = seek_base + f_amt[fmrt_pkg::POS_W-1:0];
	assign len_sat   = (f_len > fmrt_pkg::LEN_W'(fmrt_pkg::MAX_READ_BYTES))
		? fmrt_pkg::LEN_W'(fmrt_pkg::MAX_READ_BYTES) : f_len;

	assign sts.start_read = (in_mode == fmrt_pkg::MODE_READ)
		&& (f_len != '0);
	assign sts.out_free = !out_valid_q || out_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frag_count_q <= '0;
			file_len_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				fmrt_pkg::REG_FRAG_COUNT: begin
					frag_count_q <= cfg_wdata[fmrt_pkg::FRAG_CNT_W-1:0];
				end
				fmrt_pkg::REG_FILE_LENGTH: begin
					file_len_q <= cfg_wdata[fmrt_pkg::POS_W-1:0];
				end
				default: begin
					frag_count_q <= frag_count_q;
				end
			endcase
		end
	end

	// Read position, bytes left and search index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			left_q <= '0;
			idx_q <= '0;
			status_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				status_q <= 1'b0;
				idx_q <= '0;
				left_q <= len_sat;
				if (in_mode == fmrt_pkg::MODE_SEEK) begin
					case (f_origin)
						fmrt_pkg::ORG_START: begin
							pos_q <= f_amt[fmrt_pkg::POS_W-1:0];
						end
						fmrt_pkg::ORG_CURRENT, fmrt_pkg::ORG_END: begin
							pos_q <= seek_sum;
						end
						default: begin
							status_q <= 1'b1;
						end
					endcase
				end
			end
			if (cmd.test && !sts.match && !sts.search_end) begin
				idx_q <= idx_next[fmrt_pkg::FRAG_IDX_W-1:0];
			end
			if (cmd.out_load) begin
				pos_q <= pos_q + {{(fmrt_pkg::POS_W-fmrt_pkg::CHUNK_W){1'b0}}, chunk};
				left_q <= left_q - chunk_ext;
				idx_q <= '0;
			end
		end
	end

	// Match selection, with entry 0 kept as the fallback.
	always_ff @(posedge clk) begin
		if (cmd.test) begin
			if (idx_q == '0) begin
				fb_start_q <= rd_start;
				fb_lba_q <= rd_lba;
			end
			if (sts.match) begin
				sel_start_q <= rd_start;
				sel_lba_q <= rd_lba;
				hit_q <= idx_q;
			end else if (idx_q == '0) begin
				sel_start_q <= rd_start;
				sel_lba_q <= rd_lba;
				hit_q <= '0;
			end else begin
				sel_start_q <= fb_start_q;
				sel_lba_q <= fb_lba_q;
				hit_q <= '0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load || cmd.out_single) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {6'd0,
				pos_q + {{(fmrt_pkg::POS_W-fmrt_pkg::CHUNK_W){1'b0}}, chunk},
				hit_q,
				chunk == fmrt_pkg::CHUNK_W'(fmrt_pkg::SECTOR_BYTES),
				chunk, sbyte, disk_lba};
			out_status_q <= 1'b0;
			out_last_q <= sts.last_chunk;
		end else if (cmd.out_single) begin
			out_data_q <= {6'd0, pos_q, 6'd0, 1'b0,
				{fmrt_pkg::CHUNK_W{1'b0}}, {fmrt_pkg::SBYTE_W{1'b0}}, {W{1'b0}}};
			out_status_q <= status_q;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

endmodule

// ===== src/fragment_map_read_translator.sv =====
// Channel  | Signals                       | Contents
// s_*      | s_tvalid s_tready s_tdata     | load, seek and read items
//          | s_tuser                       | item kind
// m_*      | m_tvalid m_tready m_tdata     | per-sector results
//          | m_tuser m_tlast               | status, last result of an item
// cfg_*    | cfg_wr_en cfg_index cfg_wdata | fragment count, file length
//
// A load, seek or empty read goes to SINGLE, which loads its result when
// the output register is free. Each read chunk searches from slot 0,
// reading (LOOK) and testing (TEST) entries of a single-port table, until
// a match or the search end, then emits in EMIT. One item is in work at a time.
// Reset clears the position and the registers; table contents are not reset.
// A stalled output holds the result in the output register.
module fragment_map_read_translator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// entry_index, entry_start_unit, entry_disk_lba, entry_byte_size,
	// seek_origin, seek_amount, read_length
	input  logic [fmrt_pkg::IN_DATA_W-1:0]      s_tdata,
	// mode
	input  logic [1:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// disk_lba, sector_byte, chunk_bytes, whole_sector, fragment_hit,
	// position, zero fill
	output logic [fmrt_pkg::OUT_DATA_W-1:0]     m_tdata,
	// status
	output logic                                m_tuser,
	output logic                                m_tlast,
	input  logic                                cfg_wr_en,
	input  logic                                cfg_index,
	input  logic [fmrt_pkg::CFG_W-1:0]          cfg_wdata
);

	fmrt_pkg::ctl_cmd_t cmd;
	fmrt_pkg::dp_sts_t  sts;

	fmrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fmrt_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mode    (s_tuser),
		.in_data    (s_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata),
		.out_status (m_tuser),
		.out_last   (m_tlast)
	);

	// A non-empty read starts the range search in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == fmrt_pkg::MODE_READ
			&& s_tdata[fmrt_pkg::IN_LEN_LO +: fmrt_pkg::LEN_W] != '0) |=> cmd.look)
		else $error("read transfer did not start the search");

	// After the final result is loaded the block takes input again.
	assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.out_load && sts.last_chunk) || cmd.out_single) |=> s_tready)
		else $error("block not ready after the last result");

	// A result is only loaded when the output register can take it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load || cmd.out_single) |-> sts.out_free)
		else $error("result loaded over a pending one");

endmodule

// ===== tb/fragment_map_read_translator_tb.sv =====
`timescale 1ns / 100ps

module fragment_map_read_translator_tb;

	// Codes that the package leaves unnamed.
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [1:0] ORG_INVALID = 2'd3;

	localparam int CYCLE_LIMIT = 10000000;
	localparam int LONG_HOLD = 300;
	localparam int UNIT_BYTES = 1 << fmrt_pkg::UNIT_SHIFT;

	// Result field positions in m_tdata, lowest field first.
	localparam int OUT_SBYTE_LO = fmrt_pkg::WORD_W;
	localparam int OUT_CHUNK_LO = OUT_SBYTE_LO + fmrt_pkg::SBYTE_W;
	localparam int OUT_WHOLE_BIT = OUT_CHUNK_LO + fmrt_pkg::CHUNK_W;
	localparam int OUT_HIT_LO = OUT_WHOLE_BIT + 1;
	localparam int OUT_POS_LO = OUT_HIT_LO + fmrt_pkg::FRAG_IDX_W;

	typedef struct packed {
		bit [1:0] mode;
		bit [fmrt_pkg::FRAG_IDX_W-1:0] slot;
		bit [fmrt_pkg::WORD_W-1:0] start_unit;
		bit [fmrt_pkg::WORD_W-1:0] disk_lba;
		bit [fmrt_pkg::WORD_W-1:0] byte_size;
		bit [1:0] origin;
		bit [fmrt_pkg::AMT_W-1:0] amount;
		bit [fmrt_pkg::LEN_W-1:0] length;
	} file_req_t;

	localparam int REQ_W = $bits(file_req_t);

	typedef struct packed {
		bit [fmrt_pkg::WORD_W-1:0] lba;
		bit [fmrt_pkg::SBYTE_W-1:0] sbyte;
		bit [fmrt_pkg::CHUNK_W-1:0] nbytes;
		bit whole;
		bit [fmrt_pkg::FRAG_IDX_W-1:0] hit;
		bit [fmrt_pkg::POS_W-1:0] pos;
		bit status;
		bit last;
	} sector_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [fmrt_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [fmrt_pkg::OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;
	logic cfg_wr_en = 1'b0;
	logic cfg_index = 1'b0;
	logic [fmrt_pkg::CFG_W-1:0] cfg_wdata = '0;

	// Predicted block state: fragment table, position and registers.
	bit [fmrt_pkg::WORD_W-1:0] map_start [fmrt_pkg::FRAGMENTS];
	bit [fmrt_pkg::WORD_W-1:0] map_lba [fmrt_pkg::FRAGMENTS];
	bit [fmrt_pkg::WORD_W-1:0] map_size [fmrt_pkg::FRAGMENTS];
	bit [fmrt_pkg::POS_W-1:0] file_pos;
	bit [fmrt_pkg::FRAG_CNT_W-1:0] map_count;
	bit [fmrt_pkg::POS_W-1:0] map_length;

	// File layout as the stimulus builds it.
	int unsigned lay_start [fmrt_pkg::FRAGMENTS];
	int unsigned lay_units [fmrt_pkg::FRAGMENTS];
	int unsigned file_bytes;

	file_req_t req_q [$];
	sector_req_t sector_q [$];
	file_req_t cur_req;

	bit in_taken;
	bit idle_on = 1'b1;
	int unsigned in_gap, out_gap, hold_left;
	bit hold_done;
	int unsigned queued_cnt, taken_cnt, result_cnt, cycle_cnt, fail_cnt;
	int unsigned load_cnt, seek_cnt, read_cnt, chunk_cnt;

	fragment_map_read_translator dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Range search over the searched part of the table; entry 0 on a miss.
	function automatic int unsigned find_slot(bit [fmrt_pkg::UNIT_W-1:0] unit);
		int unsigned n;
		bit [fmrt_pkg::WORD_W:0] lo, hi, at;
		n = (map_count > fmrt_pkg::FRAGMENTS) ? fmrt_pkg::FRAGMENTS : 32'(map_count);
		at = {{(fmrt_pkg::WORD_W+1-fmrt_pkg::UNIT_W){1'b0}}, unit};
		for (int unsigned i = 0; i < n; i++) begin
			lo = {1'b0, map_start[i]};
			hi = lo + {1'b0, map_size[i] >> fmrt_pkg::UNIT_SHIFT};
			if (at >= lo && at < hi)
				return i;
		end
		return 0;
	endfunction

	// Applies one accepted item to the predicted state and queues its results.
	task automatic translate_req(input file_req_t r);
		sector_req_t s;
		int unsigned left, slot, cnt;
		bit [fmrt_pkg::WORD_W-1:0] sector, rel;
		s = '0;
		s.last = 1'b1;
		left = 0;
		case (r.mode)
		fmrt_pkg::MODE_LOAD: begin
			map_start[r.slot] = r.start_unit;
			map_lba[r.slot] = r.disk_lba;
			map_size[r.slot] = r.byte_size;
			load_cnt++;
		end
		fmrt_pkg::MODE_SEEK: begin
			seek_cnt++;
			case (r.origin)
			fmrt_pkg::ORG_START: file_pos = r.amount[fmrt_pkg::POS_W-1:0];
			fmrt_pkg::ORG_CURRENT: file_pos = file_pos + r.amount[fmrt_pkg::POS_W-1:0];
			fmrt_pkg::ORG_END: file_pos = map_length + r.amount[fmrt_pkg::POS_W-1:0];
			default: s.status = 1'b1;
			endcase
		end
		fmrt_pkg::MODE_READ: begin
			read_cnt++;
			left = (r.length > fmrt_pkg::MAX_READ_BYTES)
				? fmrt_pkg::MAX_READ_BYTES : 32'(r.length);
		end
		default: ;
		endcase
		if (left == 0) begin
			s.pos = file_pos;
			sector_q.push_back(s);
		end
		// Split the read into chunks that stay inside one sector.
		while (left > 0) begin
			sector = fmrt_pkg::WORD_W'(file_pos[fmrt_pkg::POS_W-1:fmrt_pkg::SECTOR_SHIFT]);
			slot = find_slot(file_pos[fmrt_pkg::POS_W-1:fmrt_pkg::UNIT_SHIFT]);
			rel = sector - {map_start[slot][fmrt_pkg::WORD_W-3:0], 2'b00};
			cnt = fmrt_pkg::SECTOR_BYTES - 32'(file_pos[fmrt_pkg::SBYTE_W-1:0]);
			if (cnt > left)
				cnt = left;
			left -= cnt;
			s.lba = map_lba[slot] + rel;
			s.sbyte = file_pos[fmrt_pkg::SBYTE_W-1:0];
			s.nbytes = fmrt_pkg::CHUNK_W'(cnt);
			s.whole = (cnt == fmrt_pkg::SECTOR_BYTES);
			s.hit = fmrt_pkg::FRAG_IDX_W'(slot);
			file_pos = file_pos + fmrt_pkg::POS_W'(cnt);
			s.pos = file_pos;
			s.last = (left == 0);
			sector_q.push_back(s);
			chunk_cnt++;
		end
	endtask

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_cnt++;
		end
	endfunction

	// Input side: offer queued items, with random idle bursts.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (in_gap > 0) begin
				in_gap--;
				s_tvalid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				in_gap = $urandom_range(0, 15);
				s_tvalid <= 1'b0;
			end else if (req_q.size() > 0) begin
				cur_req = req_q.pop_front();
				s_tdata <= {cur_req.length, cur_req.amount, cur_req.origin, cur_req.byte_size,
					cur_req.disk_lba, cur_req.start_unit, cur_req.slot};
				s_tuser <= cur_req.mode;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Output side: random stalls, and one long hold-off while items are waiting.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!hold_done && req_q.size() > 12) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_gap = $urandom_range(0, 15);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Predict on each input transfer and check each output transfer.
	always @(posedge clk) begin
		sector_req_t want;
		in_taken <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			translate_req(cur_req);
			taken_cnt++;
		end
		if (m_tvalid && m_tready) begin
			result_cnt++;
			if (sector_q.size() == 0) begin
				$error("result transfer with no result pending");
				fail_cnt++;
			end else begin
				want = sector_q.pop_front();
				check_field("disk_lba", 64'(want.lba),
					64'(m_tdata[0 +: fmrt_pkg::WORD_W]));
				check_field("sector_byte", 64'(want.sbyte),
					64'(m_tdata[OUT_SBYTE_LO +: fmrt_pkg::SBYTE_W]));
				check_field("chunk_bytes", 64'(want.nbytes),
					64'(m_tdata[OUT_CHUNK_LO +: fmrt_pkg::CHUNK_W]));
				check_field("whole_sector", 64'(want.whole),
					64'(m_tdata[OUT_WHOLE_BIT]));
				check_field("fragment_hit", 64'(want.hit),
					64'(m_tdata[OUT_HIT_LO +: fmrt_pkg::FRAG_IDX_W]));
				check_field("position", 64'(want.pos),
					64'(m_tdata[OUT_POS_LO +: fmrt_pkg::POS_W]));
				check_field("zero_fill", 64'(0),
					64'(m_tdata[fmrt_pkg::OUT_DATA_W-1:OUT_POS_LO+fmrt_pkg::POS_W]));
				check_field("status", 64'(want.status), 64'(m_tuser));
				check_field("last", 64'(want.last), 64'(m_tlast));
			end
		end
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_cnt);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic idx, input bit [fmrt_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == fmrt_pkg::REG_FRAG_COUNT)
			map_count = value[fmrt_pkg::FRAG_CNT_W-1:0];
		else
			map_length = value;
	endtask

	// The count register ignores the upper data bits, so they carry junk.
	task automatic set_regs(input int unsigned count, input bit [fmrt_pkg::POS_W-1:0] length);
		bit [fmrt_pkg::CFG_W-1:0] v;
		v = fmrt_pkg::CFG_W'({$urandom, $urandom});
		v[fmrt_pkg::FRAG_CNT_W-1:0] = fmrt_pkg::FRAG_CNT_W'(count);
		write_reg(fmrt_pkg::REG_FRAG_COUNT, v);
		write_reg(fmrt_pkg::REG_FILE_LENGTH, length);
	endtask

	// Fields that an item's kind does not use carry random values.
	function automatic file_req_t noise_req(bit [1:0] mode);
		file_req_t r;
		r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		r.mode = mode;
		return r;
	endfunction

	task automatic push_req(input file_req_t r);
		req_q.push_back(r);
		queued_cnt++;
	endtask

	task automatic load_req(input int unsigned slot,
		input bit [fmrt_pkg::WORD_W-1:0] start_unit,
		input bit [fmrt_pkg::WORD_W-1:0] lba, input bit [fmrt_pkg::WORD_W-1:0] size);
		file_req_t r;
		r = noise_req(fmrt_pkg::MODE_LOAD);
		r.slot = fmrt_pkg::FRAG_IDX_W'(slot);
		r.start_unit = start_unit;
		r.disk_lba = lba;
		r.byte_size = size;
		push_req(r);
	endtask

	task automatic seek_req(input bit [1:0] origin, input bit [fmrt_pkg::AMT_W-1:0] amount);
		file_req_t r;
		r = noise_req(fmrt_pkg::MODE_SEEK);
		r.origin = origin;
		r.amount = amount;
		push_req(r);
	endtask

	task automatic read_req(input int unsigned length);
		file_req_t r;
		r = noise_req(fmrt_pkg::MODE_READ);
		r.length = fmrt_pkg::LEN_W'(length);
		push_req(r);
	endtask

	// Put a slot back to its place in the layout, with a fresh disk sector.
	task automatic restore_slot(input int unsigned slot);
		load_req(slot, lay_start[slot], $urandom,
			(lay_units[slot] << fmrt_pkg::UNIT_SHIFT) | $urandom_range(0, UNIT_BYTES - 1));
	endtask

	task automatic drain();
		while (taken_cnt != queued_cnt || sector_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Mostly seeks into the file and reads of moderate size, plus noise.
	task automatic random_mix(input int unsigned n);
		int unsigned pick, slot;
		int offs;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			slot = $urandom_range(0, fmrt_pkg::FRAGMENTS - 1);
			if (pick < 14) begin
				restore_slot(slot);
			end else if (pick < 17) begin
				load_req(slot, $urandom, $urandom, $urandom);
				restore_slot(slot);
			end else if (pick < 35) begin
				seek_req(fmrt_pkg::ORG_START,
					fmrt_pkg::AMT_W'($urandom_range(0, file_bytes)));
			end else if (pick < 42) begin
				offs = $urandom_range(0, 8192);
				offs = offs - 4096;
				seek_req(fmrt_pkg::ORG_CURRENT, fmrt_pkg::AMT_W'(offs));
			end else if (pick < 48) begin
				offs = $urandom_range(0, file_bytes);
				offs = -offs;
				seek_req(fmrt_pkg::ORG_END, fmrt_pkg::AMT_W'(offs));
			end else if (pick < 53) begin
				seek_req(2'($urandom_range(0, 3)), fmrt_pkg::AMT_W'({$urandom, $urandom}));
			end else if (pick < 55) begin
				seek_req(ORG_INVALID, fmrt_pkg::AMT_W'({$urandom, $urandom}));
			end else if (pick < 57) begin
				push_req(noise_req(MODE_SPARE));
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 5)
					read_req(0);
				else if (pick < 70)
					read_req($urandom_range(1, 2048));
				else if (pick < 88)
					read_req($urandom_range(2049, fmrt_pkg::MAX_READ_BYTES));
				else
					read_req($urandom_range(0, (1 << fmrt_pkg::LEN_W) - 1));
			end
		end
	endtask

	initial begin
		int unsigned units;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Nothing is searched yet: every read falls back to entry 0.
		set_regs(0, '0);
		units = 0;
		for (int i = 0; i < fmrt_pkg::FRAGMENTS; i++) begin
			lay_start[i] = units;
			lay_units[i] = (i % 9 == 5) ? 0 : $urandom_range(1, 6);
			units += lay_units[i];
			restore_slot(i);
		end
		file_bytes = units * UNIT_BYTES;
		read_req(0);
		read_req(fmrt_pkg::SECTOR_BYTES);
		push_req(noise_req(MODE_SPARE));
		seek_req(ORG_INVALID, 41'h0FF_FFFF_FFFF);
		read_req(700);
		drain();

		// Full table: seeks of every origin, reads of extreme lengths, wrap.
		set_regs(fmrt_pkg::FRAGMENTS, fmrt_pkg::POS_W'(file_bytes));
		seek_req(fmrt_pkg::ORG_START, fmrt_pkg::AMT_W'(1000));
		read_req(3000);
		seek_req(fmrt_pkg::ORG_CURRENT, fmrt_pkg::AMT_W'(-500));
		read_req(1);
		seek_req(fmrt_pkg::ORG_END, fmrt_pkg::AMT_W'(-4096));
		read_req(fmrt_pkg::MAX_READ_BYTES);
		read_req((1 << fmrt_pkg::LEN_W) - 1);
		seek_req(fmrt_pkg::ORG_START, 41'h0FF_FFFF_FFF0);
		read_req(600);
		seek_req(fmrt_pkg::ORG_CURRENT, 41'h100_0000_0000);
		read_req(16);
		// Entry 0 moved past position 0: the fallback sector offset wraps.
		load_req(0, 3, 32'hFFFF_FFFF, 32'h0000_2000);
		seek_req(fmrt_pkg::ORG_START, fmrt_pkg::AMT_W'(0));
		read_req(1024);
		load_req(fmrt_pkg::FRAGMENTS - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		read_req(fmrt_pkg::SECTOR_BYTES);
		restore_slot(0);
		restore_slot(fmrt_pkg::FRAGMENTS - 1);
		drain();

		// Count above the table size is clamped.
		set_regs((1 << fmrt_pkg::FRAG_CNT_W) - 1, fmrt_pkg::POS_W'(file_bytes));
		random_mix(90);
		drain();

		// Partial search and the largest file length.
		set_regs($urandom_range(1, fmrt_pkg::FRAGMENTS - 1), {fmrt_pkg::POS_W{1'b1}});
		random_mix(80);
		drain();

		// Last part runs at full rate on both sides.
		idle_on = 1'b0;
		set_regs(fmrt_pkg::FRAGMENTS, fmrt_pkg::POS_W'(file_bytes));
		random_mix(70);
		drain();
		repeat (20) @(posedge clk);

		$display("Covered %0d items: %0d loads, %0d seeks, %0d reads in %0d sector chunks.",
			taken_cnt, load_cnt, seek_cnt, read_cnt, chunk_cnt);
		$display("Checked %0d result transfers over %0d cycles, %0d mismatches.",
			result_cnt, cycle_cnt, fail_cnt);
		if (fail_cnt == 0 && sector_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
src/fmrt_pkg.sv
src/fmrt_ctrl.sv
src/fmrt_dpath.sv
src/fragment_map_read_translator.sv
tb/fragment_map_read_translator_tb.sv
